// ===== hw/rtl/wbfr_pkg.sv =====
// Package for the windowed bit field reader.
// Holds operation codes, register indexes, field widths and default sizes.
// No dependencies.
package wbfr_pkg;

	// Field widths
	localparam int OP_W     = 2;
	localparam int ADDR_W   = 12;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 4;
	localparam int POS_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Largest bit count a read takes; larger requests saturate here
	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(BYTE_W);

	// Default store size in bytes
	localparam int BUFFER_BYTES_DEF = 4096;

	// Operation codes
	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_READ    = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIN_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_ORDER = 2'd2;

	// Bit order values
	localparam logic ORDER_MSB_FIRST = 1'b0;
	localparam logic ORDER_LSB_FIRST = 1'b1;

endpackage

// ===== hw/rtl/windowed_bit_field_reader_top.sv =====
// Windowed bit field reader, top level.
// Byte store in two synchronous memory copies, read position register, one
// output stage. Depends on wbfr_pkg.
//
// Use: item beats carry an operation (write byte, read bits, advance,
// restart). A write stores byte_value at byte_address. A read takes 0 to 8
// bits at the read position, MSB or LSB first within a byte, possibly across
// a byte boundary, and moves the position only if the field ends at or before
// the window end. Advance skips advance_bits under the same rule; restart
// returns to the window start. Every item gives exactly one result beat.
// Configuration (window start, window end, bit order) is written through the
// cfg channel, which is always ready; the user must write it only while no
// item is in flight, which the block does not enforce. Latency: a result is
// valid on the cycle after its item is accepted. Throughput: one item per
// cycle unless a result is stalled. The byte store has two copies so that
// both bytes a field may span are read in the same cycle; the read position
// is decided from the window compare alone, so the next item never waits
// for memory data. Reset: position and registers go to zero; the store is
// not cleared and a byte must be written before it is read.
// Stall: while result_stall holds a valid result, the result holds and
// item_stall is raised; otherwise an item is taken even as the result leaves.
module windowed_bit_field_reader_top #(
	parameter int BUFFER_BYTES = wbfr_pkg::BUFFER_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [wbfr_pkg::OP_W-1:0]       operation,
	input  logic [wbfr_pkg::ADDR_W-1:0]     byte_address,
	input  logic [wbfr_pkg::BYTE_W-1:0]     byte_value,
	input  logic [wbfr_pkg::COUNT_W-1:0]    bit_count,
	input  logic [wbfr_pkg::POS_W-1:0]      advance_bits,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            ok,
	output logic [wbfr_pkg::BYTE_W-1:0]     field_value,
	output logic [wbfr_pkg::POS_W-1:0]      taken_bits,
	output logic [wbfr_pkg::POS_W-1:0]      remaining_bits,
	output logic [wbfr_pkg::POS_W-1:0]      consumed_bits,
	output logic                            at_end,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wbfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbfr_pkg::POS_W-1:0]      cfg_data
);
	import wbfr_pkg::*;

	// Store geometry
	localparam int AW      = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
	localparam int IDX_W   = POS_W - 3 + 1;
	localparam int MAX_IDX = 1 << (POS_W - 3);
	localparam bit POW2    = (BUFFER_BYTES & (BUFFER_BYTES - 1)) == 0;
	localparam int NSTEP   = $clog2((MAX_IDX + 1) / BUFFER_BYTES + 1);

	// Byte index wrapped into the store, by masking for a power-of-two size, else by conditional subtraction
	function automatic logic [AW-1:0] wrap_idx(input logic [IDX_W-1:0] idx);
		int r;
		r = int'(idx);
		if (POW2) begin
			r = r & (BUFFER_BYTES - 1);
		end else begin
			for (int k = NSTEP - 1; k >= 0; k--) begin
				if (r >= (BUFFER_BYTES << k))
					r = r - (BUFFER_BYTES << k);
			end
		end
		return AW'(r);
	endfunction

	// Configuration registers
	logic [POS_W-1:0] win_start_q;
	logic [POS_W-1:0] win_end_q;
	logic             order_q;

	// Read position
	logic [POS_W-1:0] pos_q;

	// Output stage
	logic             result_valid_q;
	logic             ok_s1;
	logic             extract_s1;
	logic             second_s1;
	logic             order_s1;
	logic [2:0]       off_s1;
	logic [COUNT_W-1:0] cnt_s1;
	logic [POS_W-1:0] taken_s1;
	logic             taken_rem_s1;
	logic [BYTE_W-1:0] rd_lo_s1;
	logic [BYTE_W-1:0] rd_hi_s1;

	// Byte store, two identical copies for the two read ports
	logic [BYTE_W-1:0] mem_a [BUFFER_BYTES];
	logic [BYTE_W-1:0] mem_b [BUFFER_BYTES];

	// Accept-side decode
	logic             accept;
	logic             advance_stage;
	logic [COUNT_W-1:0] cnt;
	logic [POS_W:0]   sum_read;
	logic [POS_W:0]   sum_adv;
	logic             fit_read;
	logic             fit_adv;
	logic [2:0]       off;
	logic [IDX_W-1:0] idx;
	logic [AW-1:0]    rd_addr_lo;
	logic [AW-1:0]    rd_addr_hi;
	logic [AW-1:0]    wr_addr;
	logic             need_second;
	logic             mem_we;
	logic             mem_re;
	logic             ok_d;
	logic             extract_d;
	logic [POS_W-1:0] taken_d;
	logic             taken_rem_d;
	logic [POS_W-1:0] pos_d;

	// Output-side extraction
	logic [BYTE_W-1:0]   second_byte;
	logic [BYTE_W-1:0]   mask;
	logic [2*BYTE_W-1:0] word_msb;
	logic [2*BYTE_W-1:0] word_lsb;
	logic [4:0]          sh_msb;
	logic [BYTE_W-1:0]   ext;
	logic [POS_W-1:0]    remaining;

	// Handshake
	assign advance_stage = !result_valid_q || !result_stall;
	assign item_stall    = !advance_stage;
	assign accept        = item_valid && advance_stage;
	assign cfg_ready     = 1'b1;

	// Decode the item against the current position
	always_comb begin
		cnt         = (bit_count > MAX_COUNT) ? MAX_COUNT : bit_count;
		sum_read    = {1'b0, pos_q} + (POS_W + 1)'(cnt);
		sum_adv     = {1'b0, pos_q} + {1'b0, advance_bits};
		fit_read    = sum_read <= {1'b0, win_end_q};
		fit_adv     = sum_adv <= {1'b0, win_end_q};
		off         = pos_q[2:0];
		idx         = {1'b0, pos_q[POS_W-1:3]};
		rd_addr_lo  = wrap_idx(idx);
		rd_addr_hi  = wrap_idx(idx + IDX_W'(1));
		wr_addr     = wrap_idx(IDX_W'(byte_address));
		need_second = ({1'b0, off} + cnt) > MAX_COUNT;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		ok_d        = 1'b1;
		extract_d   = 1'b0;
		taken_d     = '0;
		taken_rem_d = 1'b0;
		pos_d       = pos_q;
		case (operation)
			OP_WRITE: begin
				mem_we = accept;
			end
			OP_READ: begin
				if (cnt != '0) begin
					if (fit_read) begin
						extract_d = 1'b1;
						mem_re    = accept;
						taken_d   = POS_W'(cnt);
						pos_d     = sum_read[POS_W-1:0];
					end else begin
						ok_d        = 1'b0;
						taken_rem_d = 1'b1;
					end
				end
			end
			OP_ADVANCE: begin
				if (fit_adv) begin
					taken_d = advance_bits;
					pos_d   = sum_adv[POS_W-1:0];
				end else begin
					ok_d = 1'b0;
				end
			end
			OP_RESTART: begin
				pos_d = win_start_q;
			end
			default: begin
				ok_d = 1'b1;
			end
		endcase
	end

	// Memory copy A: write port and low byte read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_a[wr_addr] <= byte_value;
		if (mem_re)
			rd_lo_s1 <= mem_a[rd_addr_lo];
	end

	// Memory copy B: write port and high byte read
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_b[wr_addr] <= byte_value;
		if (mem_re)
			rd_hi_s1 <= mem_b[rd_addr_hi];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= '0;
			order_q     <= ORDER_MSB_FIRST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIN_START: win_start_q <= cfg_data;
				REG_WIN_END:   win_end_q   <= cfg_data;
				REG_BIT_ORDER: order_q     <= cfg_data[0];
				default:       order_q     <= order_q;
			endcase
		end
	end

	// Read position and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept)
				pos_q <= pos_d;
			if (advance_stage)
				result_valid_q <= item_valid;
		end
	end

	// Output stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ok_s1        <= ok_d;
			extract_s1   <= extract_d;
			second_s1    <= need_second;
			order_s1     <= order_q;
			off_s1       <= off;
			cnt_s1       <= cnt;
			taken_s1     <= taken_d;
			taken_rem_s1 <= taken_rem_d;
		end
	end

	// Field extraction from the two registered bytes
	always_comb begin
		second_byte = second_s1 ? rd_hi_s1 : '0;
		mask        = BYTE_W'((9'd1 << cnt_s1) - 9'd1);
		word_msb    = {rd_lo_s1, second_byte};
		word_lsb    = {second_byte, rd_lo_s1};
		sh_msb      = 5'd16 - {2'b00, off_s1} - {1'b0, cnt_s1};
		if (order_s1 == ORDER_LSB_FIRST)
			ext = BYTE_W'(word_lsb >> off_s1) & mask;
		else
			ext = BYTE_W'(word_msb >> sh_msb) & mask;
	end

	// Position status; the position only moves on an accept, which also
	// loads the output stage, so it matches the held result
	assign remaining = (win_end_q >= pos_q) ? (win_end_q - pos_q) : '0;

	assign result_valid   = result_valid_q;
	assign ok             = ok_s1;
	assign field_value    = extract_s1 ? ext : '0;
	assign taken_bits     = taken_rem_s1 ? remaining : taken_s1;
	assign remaining_bits = remaining;
	assign consumed_bits  = (pos_q >= win_start_q) ? (pos_q - win_start_q) : '0;
	assign at_end         = pos_q == win_end_q;

endmodule

// ===== tb/windowed_bit_field_reader_top_test.sv =====
// Self-checking testbench for windowed_bit_field_reader_top: directed and random item
// traffic against a behavioural model of the byte store and the read position.
// Depends on wbfr_pkg and the windowed_bit_field_reader_top RTL.
`timescale 1ns / 1ps

module windowed_bit_field_reader_top_test;
	import wbfr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int STORE_BYTES = BUFFER_BYTES_DEF;

	typedef struct packed {
		logic                ok;
		logic [BYTE_W-1:0]   value;
		logic [POS_W-1:0]    taken;
		logic [POS_W-1:0]    remaining;
		logic [POS_W-1:0]    consumed;
		logic                at_end;
	} field_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [OP_W-1:0]       operation = OP_WRITE;
	logic [ADDR_W-1:0]     byte_address = '0;
	logic [BYTE_W-1:0]     byte_value = '0;
	logic [COUNT_W-1:0]    bit_count = '0;
	logic [POS_W-1:0]      advance_bits = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic                  ok;
	logic [BYTE_W-1:0]     field_value;
	logic [POS_W-1:0]      taken_bits;
	logic [POS_W-1:0]      remaining_bits;
	logic [POS_W-1:0]      consumed_bits;
	logic                  at_end;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_WIN_START;
	logic [POS_W-1:0]      cfg_data = '0;

	// Shadow of the block: store contents, which bytes hold data, position and registers
	logic [BYTE_W-1:0]     shadow_bytes [STORE_BYTES];
	bit                    byte_loaded [STORE_BYTES];
	int unsigned           bit_pos = 0;
	int unsigned           win_start = 0;
	int unsigned           win_end = 0;
	logic                  order_cfg = ORDER_MSB_FIRST;

	field_result_t         pending_fields [$];
	int                    mismatch_count = 0;
	int                    quiet_cycles = 0;
	int unsigned           gap_max = 11;
	int unsigned           stall_max = 11;
	int unsigned           next_gap = 0;
	bit                    items_live = 1'b0;

	windowed_bit_field_reader_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.operation      (operation),
		.byte_address   (byte_address),
		.byte_value     (byte_value),
		.bit_count      (bit_count),
		.advance_bits   (advance_bits),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.ok             (ok),
		.field_value    (field_value),
		.taken_bits     (taken_bits),
		.remaining_bits (remaining_bits),
		.consumed_bits  (consumed_bits),
		.at_end         (at_end),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin : clock_gen
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- model

	function automatic int unsigned room_left();
		return (win_end >= bit_pos) ? win_end - bit_pos : 0;
	endfunction

	// Field at the current position, spanning into the next byte if needed
	function automatic logic [BYTE_W-1:0] pick_bits(int unsigned n);
		int unsigned idx;
		int unsigned ofs;
		logic [BYTE_W-1:0] first;
		logic [BYTE_W-1:0] second;
		logic [15:0] pair;
		logic [15:0] mask;
		idx = bit_pos >> 3;
		ofs = bit_pos & 7;
		first = shadow_bytes[idx % STORE_BYTES];
		second = (ofs + n > 8) ? shadow_bytes[(idx + 1) % STORE_BYTES] : '0;
		mask = (16'd1 << n) - 16'd1;
		if (order_cfg == ORDER_LSB_FIRST) begin
			pair = {second, first};
			return BYTE_W'((pair >> ofs) & mask);
		end
		pair = {first, second};
		return BYTE_W'((pair >> (16 - ofs - n)) & mask);
	endfunction

	// Applies one accepted item to the shadow state and returns its result beat
	function automatic field_result_t step_reader(logic [OP_W-1:0] op,
		logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] val, logic [COUNT_W-1:0] cnt,
		logic [POS_W-1:0] adv);
		field_result_t r;
		int unsigned n;
		r = '0;
		r.ok = 1'b1;
		case (op)
			OP_WRITE: begin
				shadow_bytes[addr % STORE_BYTES] = val;
				byte_loaded[addr % STORE_BYTES] = 1'b1;
			end
			OP_READ: begin
				n = 32'((cnt > MAX_COUNT) ? MAX_COUNT : cnt);
				if (n != 0) begin
					if (bit_pos + n <= win_end) begin
						r.value = pick_bits(n);
						r.taken = POS_W'(n);
						bit_pos = (bit_pos + n) & 32'hffff;
					end else begin
						r.ok = 1'b0;
						r.taken = POS_W'(room_left());
					end
				end
			end
			OP_ADVANCE: begin
				if (bit_pos + 32'(adv) <= win_end) begin
					bit_pos = (bit_pos + 32'(adv)) & 32'hffff;
					r.taken = adv;
				end else begin
					r.ok = 1'b0;
				end
			end
			default: bit_pos = win_start;
		endcase
		r.remaining = POS_W'(room_left());
		r.consumed = (bit_pos >= win_start) ? POS_W'(bit_pos - win_start) : '0;
		r.at_end = (bit_pos == win_end);
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Drive one item beat and wait for it to be taken; valid stays up when the
	// next beat follows without a gap
	task automatic send_item(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
		logic [BYTE_W-1:0] val, logic [COUNT_W-1:0] cnt, logic [POS_W-1:0] adv);
		if (!items_live)
			repeat (next_gap) @(posedge clk);
		operation <= op;
		byte_address <= addr;
		byte_value <= val;
		bit_count <= cnt;
		advance_bits <= adv;
		item_valid <= 1'b1;
		items_live = 1'b1;
		do @(posedge clk); while (item_stall);
		pending_fields.push_back(step_reader(op, addr, val, cnt, adv));
		next_gap = $urandom_range(0, gap_max);
		if (next_gap != 0) begin
			item_valid <= 1'b0;
			items_live = 1'b0;
		end
	endtask

	// Called in the step of the last acceptance when no beat follows at once
	task automatic hold_items();
		if (items_live) begin
			item_valid <= 1'b0;
			items_live = 1'b0;
			if (next_gap == 0)
				next_gap = 1;
		end
	endtask

	task automatic settle_results();
		hold_items();
		while (pending_fields.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_byte(int unsigned addr, logic [BYTE_W-1:0] val);
		send_item(OP_WRITE, ADDR_W'(addr), val, COUNT_W'($urandom), POS_W'($urandom));
	endtask

	task automatic send_control(logic [OP_W-1:0] op, logic [POS_W-1:0] adv);
		send_item(op, ADDR_W'($urandom), BYTE_W'($urandom), COUNT_W'($urandom), adv);
	endtask

	// Load any byte a successful read would touch that has never been written
	task automatic load_touched_bytes(logic [COUNT_W-1:0] cnt);
		int unsigned n;
		int unsigned idx;
		n = 32'((cnt > MAX_COUNT) ? MAX_COUNT : cnt);
		if (n == 0 || bit_pos + n > win_end)
			return;
		idx = bit_pos >> 3;
		if (!byte_loaded[idx % STORE_BYTES])
			write_byte(idx % STORE_BYTES, BYTE_W'($urandom));
		if ((bit_pos & 7) + n > 8 && !byte_loaded[(idx + 1) % STORE_BYTES])
			write_byte((idx + 1) % STORE_BYTES, BYTE_W'($urandom));
	endtask

	task automatic read_bits(logic [COUNT_W-1:0] cnt);
		load_touched_bytes(cnt);
		send_item(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), cnt, POS_W'($urandom));
	endtask

	task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WIN_START: win_start = 32'(data);
			REG_WIN_END:   win_end = 32'(data);
			default:       order_cfg = data[0];
		endcase
	endtask

	// All three registers, written only once the block has gone quiet
	task automatic program_window(int unsigned lo, int unsigned hi, logic order);
		settle_results();
		cfg_beat(REG_WIN_START, POS_W'(lo));
		cfg_beat(REG_WIN_END, POS_W'(hi));
		cfg_beat(REG_BIT_ORDER, POS_W'(order));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- result side

	// Receiver stall: a random hold-off before each result beat
	initial begin : result_sink
		int unsigned n;
		forever begin
			n = $urandom_range(0, stall_max);
			if (n != 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		field_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_fields.size() == 0) begin
				$display("%0t: unexpected result beat, expected none actual value %0h ok %0b",
					$time, field_value, ok);
				mismatch_count++;
			end else begin
				want = pending_fields.pop_front();
				check_field("ok", POS_W'(want.ok), POS_W'(ok));
				check_field("field_value", POS_W'(want.value), POS_W'(field_value));
				check_field("taken_bits", want.taken, taken_bits);
				check_field("remaining_bits", want.remaining, remaining_bits);
				check_field("consumed_bits", want.consumed, consumed_bits);
				check_field("at_end", POS_W'(want.at_end), POS_W'(at_end));
			end
		end
	end

	// Watchdog on handshake progress
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Reset window is empty: reads fail, a zero advance and a zero read pass
	task automatic test_reset_window();
		read_bits(COUNT_W'(5));
		send_control(OP_ADVANCE, '0);
		read_bits('0);
		send_control(OP_RESTART, POS_W'($urandom));
	endtask

	// MSB first: fields across byte edges, saturated count, failed and exact moves
	task automatic test_msb_first();
		logic [BYTE_W-1:0] pattern [6];
		pattern = '{8'hA5, 8'hFF, 8'h00, 8'h3C, 8'h81, 8'h5A};
		program_window(4, 44, ORDER_MSB_FIRST);
		for (int i = 0; i < 6; i++)
			write_byte(i, pattern[i]);
		send_control(OP_RESTART, '0);
		read_bits(COUNT_W'(8));
		read_bits(COUNT_W'(15));
		read_bits(COUNT_W'(3));
		send_control(OP_ADVANCE, 16'h8000);
		send_control(OP_ADVANCE, POS_W'(13));
		read_bits(COUNT_W'(8));
		read_bits(COUNT_W'(1));
	endtask

	// LSB first; the register write leaves the position at the window end
	task automatic test_lsb_first();
		program_window(4, 44, ORDER_LSB_FIRST);
		send_control(OP_RESTART, '0);
		read_bits(COUNT_W'(8));
		read_bits(COUNT_W'(5));
		send_control(OP_ADVANCE, 16'hffff);
	endtask

	// Position before the window start, then past the window end
	task automatic test_outside_window();
		program_window(30, 20, ORDER_MSB_FIRST);
		read_bits(COUNT_W'(3));
		read_bits(COUNT_W'(1));
		program_window(0, 8, ORDER_MSB_FIRST);
		send_control(OP_ADVANCE, '0);
		read_bits(COUNT_W'(3));
	endtask

	// Byte index runs off the top of the store and wraps to the bottom
	task automatic test_store_wrap();
		program_window(32764, 32780, ORDER_LSB_FIRST);
		write_byte(STORE_BYTES - 1, 8'hC3);
		write_byte(0, 8'h96);
		send_control(OP_RESTART, '0);
		read_bits(COUNT_W'(8));
		read_bits(COUNT_W'(8));
	endtask

	task automatic random_phase(int unsigned kind, int unsigned items);
		int unsigned lo;
		int unsigned hi;
		int unsigned pick;
		logic [COUNT_W-1:0] cnt;
		logic [POS_W-1:0] adv;
		case (kind)
			0: begin lo = 0; hi = 32768; end
			1: begin lo = 32768; hi = 32768; end
			2: begin lo = $urandom_range(0, 32768); hi = $urandom_range(0, lo); end
			3: begin lo = 32704; hi = 32832; end
			4: begin lo = $urandom_range(32769, 65000); hi = lo + $urandom_range(0, 400); end
			default: begin lo = $urandom_range(0, 32000); hi = lo + $urandom_range(0, 400); end
		endcase
		program_window(lo, hi,
			($urandom_range(0, 1) != 0) ? ORDER_LSB_FIRST : ORDER_MSB_FIRST);
		gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
		stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
		if ($urandom_range(0, 4) != 0)
			send_control(OP_RESTART, POS_W'($urandom));
		repeat (items) begin
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				write_byte($urandom_range(0, STORE_BYTES - 1), BYTE_W'($urandom));
			end else if (pick < 72) begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					cnt = '0;
				else if (pick == 1)
					cnt = COUNT_W'($urandom_range(9, 15));
				else
					cnt = COUNT_W'($urandom_range(1, 8));
				read_bits(cnt);
			end else if (pick < 88) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					adv = POS_W'($urandom_range(0, 24));
				else if (pick < 8)
					adv = POS_W'(room_left());
				else if (pick == 8)
					adv = 16'h8000;
				else
					adv = POS_W'($urandom);
				send_control(OP_ADVANCE, adv);
			end else if (pick < 97) begin
				send_control(OP_RESTART, POS_W'($urandom));
			end else begin
				// sender holds off until the block has drained
				settle_results();
			end
		end
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 12; p++)
			random_phase((p < 5) ? p : $urandom_range(0, 7), 82);
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_msb_first();
		test_lsb_first();
		test_outside_window();
		test_store_wrap();
		test_random_traffic();
		settle_results();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/wbfr_pkg.sv
hw/rtl/windowed_bit_field_reader_top.sv
tb/windowed_bit_field_reader_top_test.sv
